// File: sv/sensor_reply_frame_checker_core_assert.svh
// ----------------------------------------------------------------------------
// Sensor reply frame checker assertion macros
// Clocked assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef SENSOR_REPLY_FRAME_CHECKER_CORE_ASSERT_SVH
`define SENSOR_REPLY_FRAME_CHECKER_CORE_ASSERT_SVH

// Check on every clock edge outside reset.
`define SRFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("srfc assertion failed");

// Check on every clock edge, reset included.
`define SRFC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("srfc assertion failed");

`endif

// File: sv/srfc_pkg.sv
// ----------------------------------------------------------------------------
// Sensor reply frame checker package
// Frame layout constants, status codes and shared types.
// ----------------------------------------------------------------------------
package srfc_pkg;

  localparam logic [7:0] FRAME_HEAD = 8'hAA;
  localparam logic [7:0] FRAME_TAIL = 8'hAB;

  localparam int unsigned PAYLOAD_BYTES = 6;
  localparam int unsigned PAYLOAD_W     = 8 * PAYLOAD_BYTES;

  localparam logic [3:0] POS_HEAD      = 4'd0;
  localparam logic [3:0] POS_ID        = 4'd1;
  localparam logic [3:0] POS_PAY_FIRST = 4'd2;
  localparam logic [3:0] POS_PAY_LAST  = 4'd7;
  localparam logic [3:0] POS_SUM       = 4'd8;
  localparam logic [3:0] POS_TAIL      = 4'd9;

  localparam int unsigned PADDR_W   = 3;
  localparam logic        REG_RESP_ID = 1'b0;
  localparam logic [7:0]  RESP_ID_RESET = 8'hC0;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_HEAD = 3'd1,
    ST_BAD_ID   = 3'd2,
    ST_BAD_SUM  = 3'd3,
    ST_BAD_TAIL = 3'd4
  } status_e;

  typedef struct packed {
    logic                 emit;
    status_e              status;
    logic [PAYLOAD_W-1:0] payload;
  } frame_res_t;

endpackage

// File: sv/srfc_frame.sv
// ----------------------------------------------------------------------------
// Sensor reply frame checker frame tracker
// Holds the frame position, running sum and payload, checks one byte a step.
// ----------------------------------------------------------------------------
module srfc_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  input  logic [7:0]         resp_id_i,
  output srfc_pkg::frame_res_t res_o
);
  import srfc_pkg::*;

  logic [3:0]           pos_q, pos_d, pos_eff;
  logic [7:0]           sum_q, sum_d;
  logic [PAYLOAD_W-1:0] store_q, store_d;
  logic                 restart;

  always_comb begin
    pos_eff = (pos_q > POS_TAIL) ? POS_HEAD : pos_q;
    res_o   = '{emit: 1'b0, status: ST_OK, payload: '0};
    pos_d   = pos_eff + 4'd1;
    sum_d   = sum_q;
    store_d = store_q;
    restart = 1'b0;
    case (pos_eff) inside
      POS_HEAD: begin
        if (byte_i != FRAME_HEAD) begin
          res_o.emit   = 1'b1;
          res_o.status = ST_BAD_HEAD;
          restart      = 1'b1;
        end
      end
      POS_ID: begin
        if (byte_i != resp_id_i) begin
          res_o.emit   = 1'b1;
          res_o.status = ST_BAD_ID;
          restart      = 1'b1;
        end
      end
      [POS_PAY_FIRST:POS_PAY_LAST]: begin
        sum_d = sum_q + byte_i;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          if (pos_eff == POS_PAY_FIRST + 4'(i)) begin
            store_d[i*8 +: 8] = byte_i;
          end
        end
      end
      POS_SUM: begin
        if (byte_i != sum_q) begin
          res_o.emit   = 1'b1;
          res_o.status = ST_BAD_SUM;
          restart      = 1'b1;
        end
      end
      default: begin
        res_o.emit = 1'b1;
        restart    = 1'b1;
        if (byte_i != FRAME_TAIL) begin
          res_o.status = ST_BAD_TAIL;
        end else begin
          res_o.payload = store_q;
        end
      end
    endcase
    if (restart) begin
      pos_d = POS_HEAD;
      sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_HEAD;
      sum_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      store_q <= store_d;
    end
  end

endmodule

// File: sv/sensor_reply_frame_checker_core.sv
// ----------------------------------------------------------------------------
// Sensor reply frame checker core
// Checks ten-byte sensor reply frames received one byte per request.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the input is not stalled. A byte is
// registered on acceptance and checked from the input register against the
// frame position, the running payload sum and the response id register. Its
// result goes into the output register as the byte leaves the input register.
// A result is either ok with six payload bytes or the first failing check
// with zero payload. Bytes that end no check give no result. The input stalls
// only while a byte waits in the input register behind a result that the
// output side is stalling. The response id register (address 0) resets to
// 0xC0 and is meant to be written while no bytes are in flight.
module sensor_reply_frame_checker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srfc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           rx_valid_i,
  output logic                           rx_stall_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           res_valid_o,
  input  logic                           res_stall_i,
  output logic [2:0]                     status_o,
  output logic [srfc_pkg::PAYLOAD_W-1:0] payload_o
);
  import srfc_pkg::*;

  logic [7:0]           resp_id_q;
  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 out_valid_q;
  logic [2:0]           out_status_q;
  logic [PAYLOAD_W-1:0] out_payload_q;
  logic                 rx_accept;
  logic                 advance;
  frame_res_t           frame_res;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_RESP_ID) ? {24'd0, resp_id_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_id_q <= RESP_ID_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == REG_RESP_ID) begin
      resp_id_q <= pwdata[7:0];
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || !res_stall_i);
  assign rx_stall_o = in_valid_q && !advance;
  assign rx_accept  = rx_valid_i && !rx_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  srfc_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .resp_id_i (resp_id_q),
    .res_o     (frame_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= frame_res.emit;
    end else if (!res_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && frame_res.emit) begin
      out_status_q  <= frame_res.status;
      out_payload_q <= frame_res.payload;
    end
  end

  assign res_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign payload_o   = out_payload_q;

endmodule

// File: sv/srfc_checker.sv
// ----------------------------------------------------------------------------
// Sensor reply frame checker port checks
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`include "sensor_reply_frame_checker_core_assert.svh"

module srfc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           rx_stall_o,
  input logic                           res_valid_o,
  input logic                           res_stall_i,
  input logic [2:0]                     status_o,
  input logic [srfc_pkg::PAYLOAD_W-1:0] payload_o
);
  import srfc_pkg::*;

  `SRFC_ASSERT(a_res_held, res_valid_o && res_stall_i |=> res_valid_o)
  `SRFC_ASSERT(a_stall_cause, rx_stall_o |-> res_valid_o && res_stall_i)
  `SRFC_ASSERT(a_err_zero, res_valid_o && status_o != ST_OK |-> payload_o == '0)
  `SRFC_ASSERT(a_status_code, res_valid_o |-> status_o <= ST_BAD_TAIL)
  `SRFC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !res_valid_o && !rx_stall_o)

endmodule

bind sensor_reply_frame_checker_core srfc_checker u_srfc_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor reply frame checker testbench
// Feeds directed and random reply frames, good, broken and stray, through the
// byte port, idling at random on both sides but in one phase. Replies are
// checked against the table or an in-bench model; the response id register
// is rewritten and read back between phases, once in the middle of a frame.
// ----------------------------------------------------------------------------
module tb_top;
  import srfc_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int SETTLE_LIMIT = 20000;
  localparam int PHASE_BYTES  = 200;
  localparam int N_ROWS       = 34;
  localparam logic [PADDR_W-1:0] RESP_ID_ADDR = PADDR_W'(4 * REG_RESP_ID);

  typedef struct packed {
    status_e              status;
    logic [PAYLOAD_W-1:0] payload;
  } reply_t;

  typedef enum logic {ROW_BYTE, ROW_SET_ID} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [7:0]           value;
    logic                 typed;
    status_e              status;
    logic [PAYLOAD_W-1:0] payload;
  } stim_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [PADDR_W-1:0]   paddr       = '0;
  logic [31:0]          pwdata      = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 rx_valid_i  = 1'b0;
  logic                 rx_stall_o;
  logic [7:0]           rx_byte_i   = '0;
  logic                 res_valid_o;
  logic                 res_stall_i = 1'b0;
  logic [2:0]           status_o;
  logic [PAYLOAD_W-1:0] payload_o;

  int unsigned idle_pct   = 22;
  int unsigned mismatches = 0;
  int unsigned bytes_fed  = 0;

  logic [3:0]           frame_pos   = POS_HEAD;
  logic [7:0]           frame_sum   = '0;
  logic [PAYLOAD_W-1:0] frame_store = '0;
  logic [7:0]           resp_id_mirror = RESP_ID_RESET;

  reply_t pending_replies [$];

  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_BYTE,   8'h00, 1'b1, ST_BAD_HEAD, 48'h0},
    '{ROW_BYTE,   8'hAA, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h55, 1'b1, ST_BAD_ID,   48'h0},
    '{ROW_BYTE,   8'hAA, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'hC0, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'hFF, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'hFF, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'hFF, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'hFF, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'hFF, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'hFF, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'hFA, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'hAB, 1'b1, ST_OK,       48'hFFFF_FFFF_FFFF},
    '{ROW_SET_ID, 8'h00, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'hAA, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h00, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h00, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h00, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h00, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h00, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h00, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h00, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h01, 1'b1, ST_BAD_SUM,  48'h0},
    '{ROW_BYTE,   8'hAA, 1'b0, ST_OK,       48'h0},
    '{ROW_SET_ID, 8'hFF, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'hFF, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h01, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h02, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h03, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h04, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h05, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h06, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h15, 1'b0, ST_OK,       48'h0},
    '{ROW_BYTE,   8'h00, 1'b1, ST_BAD_TAIL, 48'h0}
  };

  sensor_reply_frame_checker_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .rx_valid_i  (rx_valid_i),
    .rx_stall_o  (rx_stall_o),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .status_o    (status_o),
    .payload_o   (payload_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    res_stall_i <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d, payload %0h", status_o, payload_o);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (payload_o !== want.payload) begin
          $error("payload: expected %h, got %h", want.payload, payload_o);
          mismatches++;
        end
      end
    end
  end

  task automatic check_frame_byte(input logic [7:0] b, output bit got, output reply_t r);
    got = 1'b0;
    r = '{ST_OK, '0};
    if (frame_pos > POS_TAIL) begin
      frame_pos = POS_HEAD;
    end
    if (frame_pos == POS_HEAD) begin
      if (b != FRAME_HEAD) begin
        got = 1'b1;
        r.status = ST_BAD_HEAD;
      end
    end else if (frame_pos == POS_ID) begin
      if (b != resp_id_mirror) begin
        got = 1'b1;
        r.status = ST_BAD_ID;
      end
    end else if (frame_pos <= POS_PAY_LAST) begin
      frame_sum = frame_sum + b;
      frame_store[(frame_pos - POS_PAY_FIRST) * 8 +: 8] = b;
    end else if (frame_pos == POS_SUM) begin
      if (b != frame_sum) begin
        got = 1'b1;
        r.status = ST_BAD_SUM;
      end
    end else begin
      got = 1'b1;
      if (b != FRAME_TAIL) begin
        r.status = ST_BAD_TAIL;
      end else begin
        r.payload = frame_store;
      end
    end
    if (got) begin
      frame_pos = POS_HEAD;
      frame_sum = '0;
      frame_store = '0;
    end else begin
      frame_pos = frame_pos + 4'd1;
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      rx_valid_i = 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i = 1'b1;
    rx_byte_i = b;
    do @(posedge clk_i); while (rx_stall_o);
  endtask

  task automatic feed_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input reply_t typed_reply = '0);
    bit got;
    reply_t r;
    send_byte(b);
    check_frame_byte(b, got, r);
    bytes_fed++;
    if (typed) begin
      pending_replies.push_back(typed_reply);
    end else if (got) begin
      pending_replies.push_back(r);
    end
  endtask

  task automatic settle();
    int n;
    n = 0;
    @(negedge clk_i);
    rx_valid_i = 1'b0;
    while (pending_replies.size() != 0 && n < SETTLE_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_resp_id(input logic [7:0] v);
    logic [31:0] rd;
    settle();
    apb_access(1'b1, RESP_ID_ADDR, {24'h0, v}, rd);
    apb_access(1'b0, RESP_ID_ADDR, '0, rd);
    if (rd[7:0] !== v) begin
      $error("resp_id readback: expected %0h, got %0h", v, rd[7:0]);
      mismatches++;
    end
    resp_id_mirror = v;
  endtask

  task automatic send_random_frame();
    logic [7:0] frame [10];
    logic [7:0] sum;
    int k;
    int len;
    int r;
    r = $urandom_range(99);
    if (r >= 90) begin
      repeat ($urandom_range(3, 1)) feed_byte(8'($urandom_range(255)));
      return;
    end
    sum = '0;
    frame[POS_HEAD] = FRAME_HEAD;
    frame[POS_ID] = resp_id_mirror;
    for (int i = POS_PAY_FIRST; i <= POS_PAY_LAST; i++) begin
      frame[i] = 8'($urandom_range(255));
      sum = sum + frame[i];
    end
    frame[POS_SUM] = sum;
    frame[POS_TAIL] = FRAME_TAIL;
    len = 10;
    if (r >= 70) begin
      k = $urandom_range(9);
      frame[k] = frame[k] ^ 8'($urandom_range(255, 1));
      if ($urandom_range(1)) len = k + 1;
    end
    for (int i = 0; i < len; i++) begin
      feed_byte(frame[i]);
    end
  endtask

  initial begin
    logic [7:0] phase_ids [4];
    int start;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_SET_ID) begin
        set_resp_id(directed_rows[i].value);
      end else begin
        feed_byte(directed_rows[i].value, directed_rows[i].typed,
                  reply_t'{directed_rows[i].status, directed_rows[i].payload});
      end
    end

    phase_ids = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255))};
    for (int p = 0; p < 4; p++) begin
      set_resp_id(phase_ids[p]);
      idle_pct = (p == 1) ? 0 : 22;
      start = bytes_fed;
      while (bytes_fed < start + PHASE_BYTES) begin
        send_random_frame();
      end
    end
    idle_pct = 22;
    settle();

    if (pending_replies.size() != 0) begin
      $error("%0d expected replies never arrived", pending_replies.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
